FILE: sv/spc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the scanner polar-to-Cartesian converter.
// Holds the quarter-wave sine table, angle folding and config register codes.
// No dependencies.

package spc_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ARM_OFFSET = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REF_HEIGHT = 2'd1;

    localparam logic [11:0] ARM_OFFSET_RESET = 12'd39;
    localparam logic [15:0] REF_HEIGHT_RESET = 16'd1600;

    localparam logic [8:0] ANGLE_90  = 9'd90;
    localparam logic [8:0] ANGLE_180 = 9'd180;
    localparam logic [8:0] ANGLE_270 = 9'd270;
    localparam logic [8:0] ANGLE_360 = 9'd360;

    localparam logic [15:0] QUARTER_SINE [0:90] = '{
        16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,
        16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
        16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
        16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668,
        16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
        16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
        16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
        16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
        16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
        16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
        16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
        16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
        16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
        16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
        16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
        16'd31651, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
        16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
        16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
        16'd32768
    };

    typedef struct packed {
        logic       neg;
        logic [6:0] idx;
    } t_trig_sel;

    function automatic logic [8:0] wrap_angle(input logic [8:0] a);
        return (a >= ANGLE_360) ? (a - ANGLE_360) : a;
    endfunction

    function automatic t_trig_sel fold_angle(input logic [8:0] a_in);
        logic [8:0] a;
        t_trig_sel  s;
        a = wrap_angle(a_in);
        if (a <= ANGLE_90) begin
            s.neg = 1'b0;
            s.idx = a[6:0];
        end else if (a <= ANGLE_180) begin
            s.neg = 1'b0;
            s.idx = 7'(ANGLE_180 - a);
        end else if (a <= ANGLE_270) begin
            s.neg = 1'b1;
            s.idx = 7'(a - ANGLE_180);
        end else begin
            s.neg = 1'b1;
            s.idx = 7'(ANGLE_360 - a);
        end
        return s;
    endfunction

    function automatic logic [15:0] quarter_sine(input logic [6:0] idx);
        return (idx <= 7'd90) ? QUARTER_SINE[idx] : 16'd0;
    endfunction

endpackage

`default_nettype wire

FILE: sv/scanner_polar_to_cartesian.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level: scanner reading (angles, range) to Cartesian point.
// Five-stage pipeline: lookup, multiply, round, multiply, round/saturate.
// Depends on spc_pkg.
// Throughput: one beat per cycle while the output is not stalled; each
// stage advances when it is empty or its successor advances, so bubbles
// are squeezed out under output stall.
// Reset: synchronous active low; clears all stage valid bits and loads
// arm offset 39 cm and reference height 1600 cm.

module scanner_polar_to_cartesian #(
    parameter int TRIG_FRAC_BITS  = 15,
    parameter int COORD_FRAC_BITS = 4,
    parameter int RANGE_BITS      = 16
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_wr_en,
    input  wire [spc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire [15:0]                    i_cfg_data,
    input  wire                           i_valid,
    output logic                          o_stall,
    input  wire [8:0]                     i_vertical_angle,
    input  wire [8:0]                     i_horizontal_angle,
    input  wire [15:0]                    i_range_cm,
    output logic                          o_valid,
    input  wire                           i_stall,
    output logic signed [21:0]            o_x_pos,
    output logic signed [21:0]            o_y_pos,
    output logic signed [20:0]            o_vertical_drop,
    output logic signed [21:0]            o_surface_height
);

    localparam int T    = TRIG_FRAC_BITS;
    localparam int C    = COORD_FRAC_BITS;
    localparam int DB   = (RANGE_BITS < 16) ? RANGE_BITS : 16;
    localparam int TW   = T + 2;
    localparam int PW   = TW + DB + 1;
    localparam int SW   = T + 24;
    localparam int RW   = C + 22;
    localparam int XPW  = TW + RW;
    localparam int OW   = C + 24;
    localparam int DOWN = T - C;

    localparam int TRIG_UP = (T >= 15) ? (T - 15) : 0;
    localparam int TRIG_DN = (T < 15) ? (15 - T) : 0;
    localparam logic [T+16:0] TRIG_H =
        (TRIG_DN == 0) ? '0 : ((T+17)'(1) << (TRIG_DN - 1));

    localparam logic          RND_EN = (DOWN != 0);
    localparam logic [SW-1:0] DOWN_H = (DOWN == 0) ? '0 : (SW'(1) << (DOWN - 1));
    localparam logic [XPW-1:0] X_H   = XPW'(1) << (T - 1);

    localparam logic signed [OW-1:0] O_MAX = OW'(2**21 - 1);
    localparam logic signed [OW-1:0] O_MIN = OW'(-(2**21));
    localparam logic signed [RW-1:0] D_MAX = RW'(2**20 - 1);
    localparam logic signed [RW-1:0] D_MIN = RW'(-(2**20));

    function automatic logic signed [TW-1:0] trig_of(input spc_pkg::t_trig_sel s);
        logic [T+16:0] m;
        logic [TW-1:0] v;
        m = (T+17)'(spc_pkg::quarter_sine(s.idx));
        m = ((m + TRIG_H) >> TRIG_DN) << TRIG_UP;
        v = {1'b0, m[T:0]};
        return s.neg ? -v : v;
    endfunction

    // configuration
    logic [11:0] r_arm;
    logic [15:0] r_ref;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm <= spc_pkg::ARM_OFFSET_RESET;
            r_ref <= spc_pkg::REF_HEIGHT_RESET;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == spc_pkg::CFG_ARM_OFFSET) begin
                r_arm <= i_cfg_data[11:0];
            end
            if (i_cfg_index == spc_pkg::CFG_REF_HEIGHT) begin
                r_ref <= i_cfg_data;
            end
        end
    end

    // stage valids and enables
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic en1, en2, en3, en4, en5;

    assign en5     = !o_valid || !i_stall;
    assign en4     = !r_s4_valid || en5;
    assign en3     = !r_s3_valid || en4;
    assign en2     = !r_s2_valid || en3;
    assign en1     = !r_s1_valid || en2;
    assign o_stall = !en1;

    // stage 1: table lookup
    logic signed [TW-1:0] r_s1_sv, r_s1_cv, r_s1_sh, r_s1_ch;
    logic [DB-1:0]        r_s1_d;
    logic signed [TW-1:0] n_s1_sv, n_s1_cv, n_s1_sh, n_s1_ch;

    always_comb begin
        n_s1_sv = trig_of(spc_pkg::fold_angle(i_vertical_angle));
        n_s1_cv = trig_of(spc_pkg::fold_angle(
            spc_pkg::wrap_angle(i_vertical_angle) + spc_pkg::ANGLE_90));
        n_s1_sh = trig_of(spc_pkg::fold_angle(i_horizontal_angle));
        n_s1_ch = trig_of(spc_pkg::fold_angle(
            spc_pkg::wrap_angle(i_horizontal_angle) + spc_pkg::ANGLE_90));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= i_valid;
        end
        if (en1 && i_valid) begin
            r_s1_sv <= n_s1_sv;
            r_s1_cv <= n_s1_cv;
            r_s1_sh <= n_s1_sh;
            r_s1_ch <= n_s1_ch;
            r_s1_d  <= i_range_cm[DB-1:0];
        end
    end

    // stage 2: range products
    logic signed [PW-1:0] r_s2_sv_prod, r_s2_cv_prod;
    logic signed [TW-1:0] r_s2_sh, r_s2_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en2) begin
            r_s2_valid <= r_s1_valid;
        end
        if (en2 && r_s1_valid) begin
            r_s2_sv_prod <= r_s1_sv * $signed({1'b0, r_s1_d});
            r_s2_cv_prod <= r_s1_cv * $signed({1'b0, r_s1_d});
            r_s2_sh      <= r_s1_sh;
            r_s2_ch      <= r_s1_ch;
        end
    end

    // stage 3: reach and drop, rounded half away from zero
    logic signed [SW-1:0] sum_v, sum_r, sum_s, drop_v, drop_r, drop_s;
    logic signed [RW-1:0] n_s3_reach, n_s3_drop;
    logic signed [RW-1:0] r_s3_reach, r_s3_drop;
    logic signed [TW-1:0] r_s3_sh, r_s3_ch;

    always_comb begin
        sum_v      = SW'(r_s2_sv_prod) + (SW'(r_arm) << T);
        sum_r      = sum_v + DOWN_H - SW'(RND_EN & sum_v[SW-1]);
        sum_s      = sum_r >>> DOWN;
        n_s3_reach = sum_s[RW-1:0];
        drop_v     = SW'(r_s2_cv_prod);
        drop_r     = drop_v + DOWN_H - SW'(RND_EN & drop_v[SW-1]);
        drop_s     = drop_r >>> DOWN;
        n_s3_drop  = drop_s[RW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en3) begin
            r_s3_valid <= r_s2_valid;
        end
        if (en3 && r_s2_valid) begin
            r_s3_reach <= n_s3_reach;
            r_s3_drop  <= n_s3_drop;
            r_s3_sh    <= r_s2_sh;
            r_s3_ch    <= r_s2_ch;
        end
    end

    // stage 4: x/y products, surface height
    logic signed [XPW-1:0] r_s4_x_prod, r_s4_y_prod;
    logic signed [RW-1:0]  r_s4_drop;
    logic signed [OW-1:0]  r_s4_surface;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (en4) begin
            r_s4_valid <= r_s3_valid;
        end
        if (en4 && r_s3_valid) begin
            r_s4_x_prod  <= r_s3_ch * r_s3_reach;
            r_s4_y_prod  <= r_s3_sh * r_s3_reach;
            r_s4_drop    <= r_s3_drop;
            r_s4_surface <= $signed(OW'(r_ref) << C) - OW'(r_s3_drop);
        end
    end

    // stage 5: round, saturate, output register
    logic signed [XPW-1:0] x_r, x_s, y_r, y_s;
    logic signed [OW-1:0]  x_v, y_v;
    logic signed [21:0]    n_x, n_y, n_surface;
    logic signed [20:0]    n_drop;

    always_comb begin
        x_r = r_s4_x_prod + X_H - XPW'(r_s4_x_prod[XPW-1]);
        x_s = x_r >>> T;
        x_v = x_s[OW-1:0];
        y_r = r_s4_y_prod + X_H - XPW'(r_s4_y_prod[XPW-1]);
        y_s = y_r >>> T;
        y_v = y_s[OW-1:0];

        if (x_v > O_MAX) begin
            n_x = O_MAX[21:0];
        end else if (x_v < O_MIN) begin
            n_x = O_MIN[21:0];
        end else begin
            n_x = x_v[21:0];
        end

        if (y_v > O_MAX) begin
            n_y = O_MAX[21:0];
        end else if (y_v < O_MIN) begin
            n_y = O_MIN[21:0];
        end else begin
            n_y = y_v[21:0];
        end

        if (r_s4_surface > O_MAX) begin
            n_surface = O_MAX[21:0];
        end else if (r_s4_surface < O_MIN) begin
            n_surface = O_MIN[21:0];
        end else begin
            n_surface = r_s4_surface[21:0];
        end

        if (r_s4_drop > D_MAX) begin
            n_drop = D_MAX[20:0];
        end else if (r_s4_drop < D_MIN) begin
            n_drop = D_MIN[20:0];
        end else begin
            n_drop = r_s4_drop[20:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en5) begin
            o_valid <= r_s4_valid;
        end
        if (en5 && r_s4_valid) begin
            o_x_pos          <= n_x;
            o_y_pos          <= n_y;
            o_vertical_drop  <= n_drop;
            o_surface_height <= n_surface;
        end
    end

    // checks
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_s1_valid && !r_s4_valid)
        else $error("pipeline not empty after reset");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_s1_valid)
        else $error("accepted beat did not enter stage 1");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_s2_valid && r_s3_valid && r_s4_valid && o_valid))
        else $error("input stalled with a bubble in the pipeline");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !r_s4_valid) |=> !o_valid)
        else $error("output beat repeated");

endmodule

`default_nettype wire
